// ===== hdl/nads_pkg.sv =====
// Shared constants, types and the confidence table of the anchor disk splatter.
package nads_pkg;

    localparam int POS_W     = 8;
    localparam int SAMPLE_W  = 16;
    localparam int SIZE_W    = 9;
    localparam int ZOOM_W    = 13;
    localparam int RADCFG_W  = 4;
    localparam int CONF_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // Anchor coordinate: floor(pos * zoom_q8 / 256) fits in 13 bits.
    localparam int ANCHOR_W = POS_W + ZOOM_W - 8;
    // Signed pixel coordinate around an anchor, with room for the radius.
    localparam int COORD_W  = ANCHOR_W + 2;

    localparam int CONF_ENTRIES = 33;
    localparam int CONF_IDX_W   = 6;

    localparam logic [1:0] ACT_SPLAT = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd3;

    typedef struct packed {
        logic hit;
        logic last;
    } probe_t;

    // Round(32768 * 2^(-d/2)) with ties rounded up.
    function automatic logic [CONF_W-1:0] conf_q15(input logic [CONF_IDX_W-1:0] d);
        logic [CONF_W-1:0] c;
        case (d)
            6'd0:  c = 16'd32768;
            6'd1:  c = 16'd23170;
            6'd2:  c = 16'd16384;
            6'd3:  c = 16'd11585;
            6'd4:  c = 16'd8192;
            6'd5:  c = 16'd5793;
            6'd6:  c = 16'd4096;
            6'd7:  c = 16'd2896;
            6'd8:  c = 16'd2048;
            6'd9:  c = 16'd1448;
            6'd10: c = 16'd1024;
            6'd11: c = 16'd724;
            6'd12: c = 16'd512;
            6'd13: c = 16'd362;
            6'd14: c = 16'd256;
            6'd15: c = 16'd181;
            6'd16: c = 16'd128;
            6'd17: c = 16'd91;
            6'd18: c = 16'd64;
            6'd19: c = 16'd45;
            6'd20: c = 16'd32;
            6'd21: c = 16'd23;
            6'd22: c = 16'd16;
            6'd23: c = 16'd11;
            6'd24: c = 16'd8;
            6'd25: c = 16'd6;
            6'd26: c = 16'd4;
            6'd27: c = 16'd3;
            6'd28: c = 16'd2;
            6'd29: c = 16'd1;
            6'd30: c = 16'd1;
            6'd31: c = 16'd1;
            6'd32: c = 16'd1;
            default: c = 16'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/nads_scan.sv =====
// Walks the square around one anchor and emits one pixel probe per cycle.
module nads_scan #(
    parameter int MAX_MAP_WIDTH  = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int MAX_RADIUS     = 15
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          go,
    input  logic [nads_pkg::ANCHOR_W-1:0]                 anchor_x,
    input  logic [nads_pkg::ANCHOR_W-1:0]                 anchor_y,
    input  logic [$clog2(MAX_RADIUS+1)-1:0]               rad,
    input  logic [$clog2(MAX_RADIUS*MAX_RADIUS+1)-1:0]    rad_sq,
    input  logic [nads_pkg::SIZE_W-1:0]                   map_width,
    input  logic [nads_pkg::SIZE_W-1:0]                   map_height,
    output nads_pkg::probe_t                              probe,
    output logic [$clog2(MAX_MAP_WIDTH*MAX_MAP_HEIGHT)-1:0] probe_addr,
    output logic [$clog2(MAX_RADIUS*MAX_RADIUS+1)-1:0]    probe_dist
);
    import nads_pkg::*;

    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int DW     = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
    localparam int OW     = RW + 1;
    localparam int DXW    = RW + 2;
    localparam int SW     = 2 * DXW;
    localparam int XW     = $clog2(MAX_MAP_WIDTH);
    localparam int YW     = $clog2(MAX_MAP_HEIGHT);
    localparam int ADDR_W = $clog2(MAX_MAP_WIDTH * MAX_MAP_HEIGHT);

    logic                  active_reg;
    logic [ANCHOR_W-1:0]   ax_reg, ay_reg;
    logic [RW-1:0]         r_reg;
    logic [DW-1:0]         rr_reg;
    logic [OW-1:0]         ox_reg, oy_reg;

    logic [OW-1:0]         span_m1;
    logic signed [COORD_W-1:0] x_c, y_c;
    logic signed [DXW-1:0] dx, dy;
    logic signed [SW-1:0]  dx_e, dy_e;
    logic [SW-1:0]         d_sum;
    logic                  in_map;
    logic                  at_end;
    logic [XW-1:0]         xi;
    logic [YW-1:0]         yi;
    probe_t                probe_next;

    always_comb
    begin
        span_m1 = (OW'(r_reg) << 1) - OW'(1);
        x_c = $signed(COORD_W'(ax_reg)) - $signed(COORD_W'(r_reg)) + $signed(COORD_W'(ox_reg));
        y_c = $signed(COORD_W'(ay_reg)) - $signed(COORD_W'(r_reg)) + $signed(COORD_W'(oy_reg));
        dx = $signed(DXW'(ox_reg)) - $signed(DXW'(r_reg));
        dy = $signed(DXW'(oy_reg)) - $signed(DXW'(r_reg));
        dx_e = SW'(dx);
        dy_e = SW'(dy);
        d_sum = $unsigned(SW'(dx_e * dx_e)) + $unsigned(SW'(dy_e * dy_e));
        in_map = (x_c >= 0) && (y_c >= 0)
              && (x_c < $signed(COORD_W'(map_width)))
              && (y_c < $signed(COORD_W'(map_height)))
              && (x_c < $signed(COORD_W'(MAX_MAP_WIDTH)))
              && (y_c < $signed(COORD_W'(MAX_MAP_HEIGHT)));
        at_end = (ox_reg == span_m1) && (oy_reg == span_m1);
        xi = x_c[XW-1:0];
        yi = y_c[YW-1:0];
        probe_next.hit  = active_reg && in_map && (d_sum < SW'(rr_reg));
        // A zero radius has no pixels; the walk ends as soon as it starts.
        probe_next.last = (go && (rad == '0)) || (active_reg && at_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            probe      <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
        end
        else
        begin
            probe <= probe_next;
            if (go)
            begin
                active_reg <= (rad != '0);
                ox_reg     <= '0;
                oy_reg     <= '0;
            end
            else if (active_reg)
            begin
                if (at_end)
                begin
                    active_reg <= 1'b0;
                end
                else if (ox_reg == span_m1)
                begin
                    ox_reg <= '0;
                    oy_reg <= oy_reg + OW'(1);
                end
                else
                begin
                    ox_reg <= ox_reg + OW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            ax_reg <= anchor_x;
            ay_reg <= anchor_y;
            r_reg  <= rad;
            rr_reg <= rad_sq;
        end
        probe_addr <= ADDR_W'(yi) * ADDR_W'(MAX_MAP_WIDTH) + ADDR_W'(xi);
        probe_dist <= DW'(d_sum);
    end

endmodule

// ===== hdl/nearest_anchor_disk_splat.sv =====
// Top level of the anchor disk splatter: command port, pixel store and read path.
// An in-map read gives its beat from ST_READ, an off-map read a blank beat from the accept.
// A nonzero splat passes ST_ANCHOR, ST_SCAN, ST_DRAIN: the walk tests and rewrites one pixel
// per cycle via the separate read and write ports of the store. A clear zeroes all pixels.
// After reset the store is swept to zero, all MAX_MAP_WIDTH*MAX_MAP_HEIGHT pixels (65536 by
// default), with busy high; configuration writes are taken throughout.
// The receiver cannot stall: each result beat is shown for one cycle with result_valid.
module nearest_anchor_disk_splat #(
    parameter int MAX_MAP_WIDTH  = 256,
    parameter int MAX_MAP_HEIGHT = 256,
    parameter int MAX_RADIUS     = 15,
    parameter int DEPTH_BITS     = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic [nads_pkg::POS_W-1:0]         pos_x,
    input  logic [nads_pkg::POS_W-1:0]         pos_y,
    input  logic [nads_pkg::SAMPLE_W-1:0]      sample_depth,
    output logic                               result_valid,
    output logic [nads_pkg::SAMPLE_W-1:0]      pixel_depth,
    output logic                               painted,
    output logic [nads_pkg::CONF_W-1:0]        confidence,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nads_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nads_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import nads_pkg::*;

    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int DW     = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
    localparam int PIXELS = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
    localparam int ADDR_W = $clog2(PIXELS);
    localparam int WORD_W = 1 + DW + DEPTH_BITS;
    localparam int PROD_W = POS_W + ZOOM_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CLEAR  = 3'd1;
    localparam logic [2:0] ST_ANCHOR = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     clr_cnt_reg;

    logic [SIZE_W-1:0]     map_width_reg, map_height_reg;
    logic [ZOOM_W-1:0]     zoom_reg;
    logic [RADCFG_W-1:0]   radius_reg;

    logic [POS_W-1:0]      px_reg, py_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [DEPTH_BITS-1:0] depth_in;

    logic [WORD_W-1:0]     mem [PIXELS];
    logic [WORD_W-1:0]     rdata_reg;
    logic                  rd_en, wr_en;
    logic [ADDR_W-1:0]     raddr, waddr;
    logic [WORD_W-1:0]     wdata;

    logic [ADDR_W-1:0]     upd_addr_reg;
    logic [DW-1:0]         upd_dist_reg;
    logic                  upd_hit_reg;
    logic                  upd_write;

    logic                  accept;
    logic                  rd_inside;
    logic [ADDR_W-1:0]     rd_addr;

    logic [PROD_W-1:0]     prod_x, prod_y;
    logic [RW-1:0]         rad_eff;
    logic [DW-1:0]         rad_sq;
    logic                  scan_go;
    probe_t                probe;
    logic [ADDR_W-1:0]     probe_addr;
    logic [DW-1:0]         probe_dist;

    logic                  old_painted;
    logic [DW-1:0]         old_dist;
    logic [DEPTH_BITS-1:0] old_depth;
    logic [31:0]           dist_wide;

    logic                  result_valid_reg;
    logic [SAMPLE_W-1:0]   pixel_depth_reg;
    logic                  painted_reg;
    logic [CONF_W-1:0]     confidence_reg;

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign accept       = start && !busy;
    assign depth_in     = DEPTH_BITS'(sample_depth);
    assign result_valid = result_valid_reg;
    assign pixel_depth  = pixel_depth_reg;
    assign painted      = painted_reg;
    assign confidence   = confidence_reg;

    assign rd_inside = (16'(pos_x) < 16'(map_width_reg)) && (16'(pos_x) < 16'(MAX_MAP_WIDTH))
                    && (16'(pos_y) < 16'(map_height_reg)) && (16'(pos_y) < 16'(MAX_MAP_HEIGHT));
    assign rd_addr   = ADDR_W'(pos_y) * ADDR_W'(MAX_MAP_WIDTH) + ADDR_W'(pos_x);

    // Anchors and radius are formed once per splat and latched by the walker.
    assign prod_x  = PROD_W'(px_reg) * PROD_W'(zoom_reg);
    assign prod_y  = PROD_W'(py_reg) * PROD_W'(zoom_reg);
    assign rad_eff = (32'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
    assign rad_sq  = DW'(rad_eff) * DW'(rad_eff);
    assign scan_go = (state_reg == ST_ANCHOR);

    nads_scan #(
        .MAX_MAP_WIDTH  (MAX_MAP_WIDTH),
        .MAX_MAP_HEIGHT (MAX_MAP_HEIGHT),
        .MAX_RADIUS     (MAX_RADIUS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (scan_go),
        .anchor_x   (prod_x[PROD_W-1:8]),
        .anchor_y   (prod_y[PROD_W-1:8]),
        .rad        (rad_eff),
        .rad_sq     (rad_sq),
        .map_width  (map_width_reg),
        .map_height (map_height_reg),
        .probe      (probe),
        .probe_addr (probe_addr),
        .probe_dist (probe_dist)
    );

    assign old_painted = rdata_reg[WORD_W-1];
    assign old_dist    = rdata_reg[DEPTH_BITS +: DW];
    assign old_depth   = rdata_reg[DEPTH_BITS-1:0];
    assign dist_wide   = 32'(old_dist);

    // The walk never visits a pixel twice, so a write in the cycle after its read
    // cannot collide with the next read. On equal distance the earlier sample stays.
    assign upd_write = upd_hit_reg && (!old_painted || (upd_dist_reg < old_dist));

    always_comb
    begin
        rd_en = 1'b0;
        raddr = rd_addr;
        if (state_reg == ST_SCAN)
        begin
            rd_en = probe.hit;
            raddr = probe_addr;
        end
        else if (accept && (action == ACT_READ) && rd_inside)
        begin
            rd_en = 1'b1;
        end
        wr_en = (state_reg == ST_CLEAR) || upd_write;
        waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : upd_addr_reg;
        wdata = (state_reg == ST_CLEAR) ? '0 : {1'b1, upd_dist_reg, depth_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_SPLAT: state_next = (depth_in != '0) ? ST_ANCHOR : ST_IDLE;
                        ACT_READ:  state_next = rd_inside ? ST_READ : ST_IDLE;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR:  state_next = (clr_cnt_reg == ADDR_W'(PIXELS - 1)) ? ST_IDLE : ST_CLEAR;
            ST_ANCHOR: state_next = ST_SCAN;
            ST_SCAN:   state_next = probe.last ? ST_DRAIN : ST_SCAN;
            ST_DRAIN:  state_next = ST_IDLE;
            ST_READ:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            upd_hit_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            map_width_reg    <= SIZE_W'(256);
            map_height_reg   <= SIZE_W'(256);
            zoom_reg         <= ZOOM_W'(256);
            radius_reg       <= RADCFG_W'(4);
        end
        else
        begin
            state_reg   <= state_next;
            upd_hit_reg <= (state_reg == ST_SCAN) && probe.hit;

            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            else
            begin
                clr_cnt_reg <= '0;
            end

            result_valid_reg <= (state_reg == ST_READ)
                             || (accept && (action == ACT_READ) && !rd_inside);

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MAP_WIDTH:  map_width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_MAP_HEIGHT: map_height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_ZOOM:       zoom_reg       <= cfg_data[ZOOM_W-1:0];
                    CFG_RADIUS:     radius_reg     <= cfg_data[RADCFG_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            depth_reg <= depth_in;
        end
        upd_addr_reg <= probe_addr;
        upd_dist_reg <= probe_dist;

        if (state_reg == ST_READ)
        begin
            pixel_depth_reg <= old_painted ? SAMPLE_W'(old_depth) : '0;
            painted_reg     <= old_painted;
            confidence_reg  <= (old_painted && (dist_wide < CONF_ENTRIES))
                             ? conf_q15(dist_wide[CONF_IDX_W-1:0]) : '0;
        end
        else
        begin
            pixel_depth_reg <= '0;
            painted_reg     <= 1'b0;
            confidence_reg  <= '0;
        end
    end

endmodule

// ===== tb/nads_checker.sv =====
// Checker for the anchor disk splatter: tracks the pixel store, predicts each read beat and compares.
module nads_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      action,
    input  logic [nads_pkg::POS_W-1:0]      pos_x,
    input  logic [nads_pkg::POS_W-1:0]      pos_y,
    input  logic [nads_pkg::SAMPLE_W-1:0]   sample_depth,
    input  logic                            result_valid,
    input  logic [nads_pkg::SAMPLE_W-1:0]   pixel_depth,
    input  logic                            painted,
    input  logic [nads_pkg::CONF_W-1:0]     confidence,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [nads_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nads_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import nads_pkg::*;

    localparam int MAP_MAX_W = 256;
    localparam int MAP_MAX_H = 256;
    localparam int RAD_MAX   = 15;
    localparam int PIXELS    = MAP_MAX_W * MAP_MAX_H;

    typedef struct packed {
        logic [SAMPLE_W-1:0] depth;
        logic                hit;
        logic [CONF_W-1:0]   conf;
    } pixel_read_t;

    pixel_read_t pending_reads[$];

    logic [SAMPLE_W-1:0] depth_mem [0:PIXELS-1];
    logic [7:0]          dist_mem  [0:PIXELS-1];
    logic                paint_mem [0:PIXELS-1];

    logic [SIZE_W-1:0]   cfg_w;
    logic [SIZE_W-1:0]   cfg_h;
    logic [ZOOM_W-1:0]   cfg_zoom;
    logic [RADCFG_W-1:0] cfg_rad;

    int          fails;
    pixel_read_t want;

    initial begin
        fail_count = 0;
        pending    = 0;
        fails      = 0;
    end

    function automatic int eff_width();
        return (int'(cfg_w) > MAP_MAX_W) ? MAP_MAX_W : int'(cfg_w);
    endfunction

    function automatic int eff_height();
        return (int'(cfg_h) > MAP_MAX_H) ? MAP_MAX_H : int'(cfg_h);
    endfunction

    // Q15 value of 2^(-d/2), halves rounded up; beyond d = 32 it rounds to zero.
    function automatic logic [CONF_W-1:0] conf_of(input int d);
        real v;
        if (d > 32)
            return '0;
        v = 32768.0 * (2.0 ** (-0.5 * d));
        return CONF_W'(int'($floor(v + 0.5)));
    endfunction

    task automatic wipe_store();
        for (int i = 0; i < PIXELS; i++)
        begin
            depth_mem[i] = '0;
            dist_mem[i]  = '0;
            paint_mem[i] = 1'b0;
        end
    endtask

    task automatic paint_disk(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                              input logic [SAMPLE_W-1:0] dep);
        int w, h, r, xc, yc, x, y, d, idx;
        w  = eff_width();
        h  = eff_height();
        r  = (int'(cfg_rad) > RAD_MAX) ? RAD_MAX : int'(cfg_rad);
        xc = (int'(px) * int'(cfg_zoom)) >> 8;
        yc = (int'(py) * int'(cfg_zoom)) >> 8;
        for (y = yc - r; y < yc + r; y++)
        begin
            for (x = xc - r; x < xc + r; x++)
            begin
                if (x >= 0 && y >= 0 && x < w && y < h)
                begin
                    d = (x - xc) * (x - xc) + (y - yc) * (y - yc);
                    idx = y * MAP_MAX_W + x;
                    // An equal distance leaves the pixel with the earlier sample.
                    if (d < r * r && (!paint_mem[idx] || d < int'(dist_mem[idx])))
                    begin
                        depth_mem[idx] = dep;
                        dist_mem[idx]  = 8'(d);
                        paint_mem[idx] = 1'b1;
                    end
                end
            end
        end
    endtask

    function automatic pixel_read_t read_pixel(input logic [POS_W-1:0] px,
                                               input logic [POS_W-1:0] py);
        pixel_read_t e;
        int idx;
        e = '0;
        if (int'(px) < eff_width() && int'(py) < eff_height())
        begin
            idx = int'(py) * MAP_MAX_W + int'(px);
            if (paint_mem[idx])
            begin
                e.depth = depth_mem[idx];
                e.hit   = 1'b1;
                e.conf  = conf_of(int'(dist_mem[idx]));
            end
        end
        return e;
    endfunction

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] act_v);
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
        fails++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cfg_w    = 9'd256;
            cfg_h    = 9'd256;
            cfg_zoom = 13'd256;
            cfg_rad  = 4'd4;
            wipe_store();
            pending_reads.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_reads.size() == 0)
                begin
                    $display("%0t: read beat with none outstanding, depth %h painted %b conf %h",
                             $time, pixel_depth, painted, confidence);
                    fails++;
                end
                else
                begin
                    want = pending_reads.pop_front();
                    if (pixel_depth !== want.depth)
                        report_field("pixel_depth", want.depth, pixel_depth);
                    if (painted !== want.hit)
                        report_field("painted", 16'(want.hit), 16'(painted));
                    if (confidence !== want.conf)
                        report_field("confidence", want.conf, confidence);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAP_WIDTH:  cfg_w    = cfg_data[SIZE_W-1:0];
                    CFG_MAP_HEIGHT: cfg_h    = cfg_data[SIZE_W-1:0];
                    CFG_ZOOM:       cfg_zoom = cfg_data[ZOOM_W-1:0];
                    CFG_RADIUS:     cfg_rad  = cfg_data[RADCFG_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (action)
                    ACT_SPLAT:
                        if (sample_depth != '0)
                            paint_disk(pos_x, pos_y, sample_depth);
                    ACT_READ:  pending_reads.push_back(read_pixel(pos_x, pos_y));
                    ACT_CLEAR: wipe_store();
                    default: ;
                endcase
            end
        end
        fail_count <= fails;
        pending    <= pending_reads.size();
    end

endmodule

// ===== tb/tb_nearest_anchor_disk_splat.sv =====
// Testbench top for the anchor disk splatter: clock, reset, command and register stimulus, verdict.
module tb_nearest_anchor_disk_splat;
    timeunit 1ns;
    timeprecision 1ps;

    import nads_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            action;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [SAMPLE_W-1:0]   sample_depth;
    logic                  result_valid;
    logic [SAMPLE_W-1:0]   pixel_depth;
    logic                  painted;
    logic [CONF_W-1:0]     confidence;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int cycle_count;

    // Current register values, used only to aim the stimulus.
    int cur_zoom;
    int cur_radius;
    int anchor_x [0:7];
    int anchor_y [0:7];
    int anchor_next;
    int clears_left;

    nearest_anchor_disk_splat DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .sample_depth (sample_depth),
        .result_valid (result_valid),
        .pixel_depth  (pixel_depth),
        .painted      (painted),
        .confidence   (confidence),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    nads_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .sample_depth (sample_depth),
        .result_valid (result_valid),
        .pixel_depth  (pixel_depth),
        .painted      (painted),
        .confidence   (confidence),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // A command beat is taken at the first edge with start high and busy low.
    // Start is left high so that a following beat can go out back to back.
    task automatic issue(input logic [1:0] a, input logic [POS_W-1:0] x,
                         input logic [POS_W-1:0] y, input logic [SAMPLE_W-1:0] d);
        action       <= a;
        pos_x        <= x;
        pos_y        <= y;
        sample_depth <= d;
        start        <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic gap(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Splats and clears give no beat back, so also wait until the block drops busy.
    task automatic settle();
        drain_results();
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input int w, input int h, input int z, input int r);
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_MAP_WIDTH, w);
            write_reg(CFG_MAP_HEIGHT, h);
            write_reg(CFG_ZOOM, z);
            write_reg(CFG_RADIUS, r);
        end
        else
        begin
            write_reg(CFG_RADIUS, r);
            write_reg(CFG_ZOOM, z);
            write_reg(CFG_MAP_HEIGHT, h);
            write_reg(CFG_MAP_WIDTH, w);
        end
        cfg_valid  <= 1'b0;
        cur_zoom   = z;
        cur_radius = r;
    endtask

    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return $urandom_range(257, 511);
        if (roll == 1)
            return $urandom_range(1, 64);
        return 256;
    endfunction

    task automatic random_config();
        int w, h, z, r, roll;
        w = pick_size();
        h = pick_size();
        roll = $urandom_range(0, 9);
        if (roll == 0)
            z = 0;
        else if (roll == 1)
            z = $urandom_range(1, 127);
        else if (roll <= 6)
            z = $urandom_range(128, 512);
        else if (roll <= 8)
            z = 256;
        else
            z = $urandom_range(0, 8191);
        roll = $urandom_range(0, 19);
        if (roll == 0)
            r = 0;
        else if (roll <= 12)
            r = $urandom_range(1, 6);
        else
            r = $urandom_range(7, 15);
        set_config(w, h, z, r);
    endtask

    function automatic logic [POS_W-1:0] clamp_pos(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return POS_W'(v);
    endfunction

    task automatic random_item();
        int roll, k, lim, span;
        logic [POS_W-1:0] x, y;
        logic [SAMPLE_W-1:0] dep;
        roll = $urandom_range(0, 99);
        if (roll < 44)
        begin
            // Keep most anchors inside the readable part of the map.
            lim = (cur_zoom <= 256) ? 255 : 65280 / cur_zoom;
            if ($urandom_range(0, 9) < 3)
            begin
                x = POS_W'($urandom);
                y = POS_W'($urandom);
            end
            else
            begin
                x = POS_W'($urandom_range(0, lim));
                y = POS_W'($urandom_range(0, lim));
            end
            dep = SAMPLE_W'($urandom);
            if (dep == '0)
                dep = 16'hFFFF;
            anchor_x[anchor_next] = (int'(x) * cur_zoom) >> 8;
            anchor_y[anchor_next] = (int'(y) * cur_zoom) >> 8;
            anchor_next = (anchor_next + 1) % 8;
            issue(ACT_SPLAT, x, y, dep);
        end
        else if (roll < 47)
            issue(ACT_SPLAT, POS_W'($urandom), POS_W'($urandom), '0);
        else if (roll < 49)
            issue(ACT_UNUSED, POS_W'($urandom), POS_W'($urandom), SAMPLE_W'($urandom));
        else if (roll < 50 && clears_left > 0)
        begin
            clears_left--;
            issue(ACT_CLEAR, POS_W'($urandom), POS_W'($urandom), SAMPLE_W'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, 7);
                span = cur_radius + 1;
                x = clamp_pos(anchor_x[k] + int'($urandom_range(0, 2 * span)) - span);
                y = clamp_pos(anchor_y[k] + int'($urandom_range(0, 2 * span)) - span);
            end
            else
            begin
                x = POS_W'($urandom);
                y = POS_W'($urandom);
            end
            issue(ACT_READ, x, y, SAMPLE_W'($urandom));
        end
    endtask

    task automatic run_random(input int n);
        int done, len, i;
        done = 0;
        while (done < n)
        begin
            len = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            for (i = 0; i < len && done < n; i++)
            begin
                random_item();
                done++;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: ;
                3:       drain_results();
                default: gap($urandom_range(1, 15));
            endcase
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_SPLAT;
        pos_x        = '0;
        pos_y        = '0;
        sample_depth = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_MAP_WIDTH;
        cfg_data     = '0;
        cur_zoom     = 256;
        cur_radius   = 4;
        anchor_next  = 0;
        clears_left  = 3;
        for (int i = 0; i < 8; i++)
        begin
            anchor_x[i] = 0;
            anchor_y[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, written anyway; the store sweep after reset runs meanwhile.
        set_config(256, 256, 256, 4);
        issue(ACT_READ, 8'd0, 8'd0, 16'd0);
        issue(ACT_SPLAT, 8'd10, 8'd10, 16'hFFFF);
        issue(ACT_SPLAT, 8'd20, 8'd20, 16'd0);
        issue(ACT_READ, 8'd20, 8'd20, 16'd0);
        issue(ACT_READ, 8'd10, 8'd10, 16'd0);
        issue(ACT_READ, 8'd11, 8'd12, 16'd0);
        issue(ACT_READ, 8'd13, 8'd10, 16'd0);
        gap(3);
        issue(ACT_READ, 8'd14, 8'd10, 16'd0);
        issue(ACT_READ, 8'd6, 8'd6, 16'd0);
        // Pixel (12,10) is equally far from both anchors, so the first sample keeps it.
        issue(ACT_SPLAT, 8'd14, 8'd10, 16'h1234);
        issue(ACT_READ, 8'd12, 8'd10, 16'd0);
        issue(ACT_READ, 8'd13, 8'd10, 16'd0);
        issue(ACT_SPLAT, 8'd0, 8'd0, 16'h0001);
        issue(ACT_READ, 8'd0, 8'd0, 16'd0);
        issue(ACT_SPLAT, 8'd255, 8'd255, 16'h8000);
        issue(ACT_READ, 8'd255, 8'd255, 16'd0);
        issue(ACT_READ, 8'd253, 8'd254, 16'd0);
        issue(ACT_UNUSED, 8'd255, 8'd255, 16'hFFFF);
        issue(ACT_READ, 8'd255, 8'd255, 16'd0);
        issue(ACT_CLEAR, 8'd0, 8'd0, 16'd0);
        issue(ACT_READ, 8'd10, 8'd10, 16'd0);
        issue(ACT_READ, 8'd255, 8'd0, 16'd0);
        settle();

        // Empty map: nothing paints and every read comes back blank.
        set_config(0, 0, 256, 4);
        issue(ACT_SPLAT, 8'd1, 8'd1, 16'h0005);
        issue(ACT_READ, 8'd0, 8'd0, 16'd0);
        issue(ACT_READ, 8'd255, 8'd255, 16'd0);
        settle();

        // Oversized map, largest zoom and radius.
        set_config(511, 300, 8191, 15);
        issue(ACT_SPLAT, 8'd0, 8'd0, 16'h7777);
        issue(ACT_SPLAT, 8'd1, 8'd1, 16'h0F0F);
        issue(ACT_SPLAT, 8'd255, 8'd255, 16'hAAAA);
        issue(ACT_READ, 8'd0, 8'd0, 16'd0);
        issue(ACT_READ, 8'd14, 8'd0, 16'd0);
        issue(ACT_READ, 8'd31, 8'd31, 16'd0);
        issue(ACT_READ, 8'd20, 8'd20, 16'd0);
        settle();

        // Zero zoom puts every anchor on the corner pixel.
        set_config(1, 1, 0, 15);
        issue(ACT_SPLAT, 8'd200, 8'd100, 16'h5555);
        issue(ACT_SPLAT, 8'd7, 8'd9, 16'h3333);
        issue(ACT_READ, 8'd0, 8'd0, 16'd0);
        issue(ACT_READ, 8'd1, 8'd0, 16'd0);
        settle();

        // Radius zero paints nothing; the shrunken map hides what lies outside it.
        set_config(16, 16, 256, 0);
        issue(ACT_SPLAT, 8'd5, 8'd5, 16'h9999);
        issue(ACT_READ, 8'd5, 8'd5, 16'd0);
        issue(ACT_READ, 8'd20, 8'd20, 16'd0);
        settle();

        // Distances at and past the end of the confidence table, and just outside the disk.
        set_config(256, 256, 256, 15);
        issue(ACT_READ, 8'd20, 8'd20, 16'd0);
        issue(ACT_SPLAT, 8'd100, 8'd100, 16'h4242);
        issue(ACT_READ, 8'd104, 8'd104, 16'd0);
        issue(ACT_READ, 8'd104, 8'd105, 16'd0);
        issue(ACT_READ, 8'd114, 8'd100, 16'd0);
        issue(ACT_READ, 8'd86, 8'd86, 16'd0);
        issue(ACT_READ, 8'd115, 8'd100, 16'd0);
        settle();

        for (int ph = 0; ph < 7; ph++)
        begin
            random_config();
            run_random(80);
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
